@@ rtl/sdq_pkg.sv @@
// shared types and codes for the sorted double-ended queue
// no dependencies; used by the controller, the top level and the checker
`timescale 1ns / 1ps

package sdq_pkg;

  // default number of held values
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned MODE_W   = 2;

  // request codes
  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REM_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REM_MAX = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // finished request from the controller to the output stage
  typedef struct packed {
    logic                       valid;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  removed;
    logic [COUNT_W-1:0]         count;
    logic signed [VALUE_W-1:0]  min_value;
    logic signed [VALUE_W-1:0]  max_value;
  } rsp_t;

endpackage

@@ rtl/sorted_double_ended_queue.sv @@
// top level of the sorted double-ended queue: controller and result register
// depends on sdq_pkg, sdq_ctrl (which holds the sdq_ram)
`timescale 1ns / 1ps

// Usage:
//   A request beat (mode_i, value_i) is taken at a rising edge with start_i
//   high and busy_o low. Mode insert puts value_i at its sorted place, ahead
//   of equal values; the remove modes take out the smallest or the largest.
//   Each request yields one result beat, marked by done_o for one cycle:
//   status_o, removed_value_o, count_o, min_value_o and max_value_o.
//   From accept to done_o: an insert into an empty list, full/empty
//   reports, unused codes and removing the only entry pass the response
//   state and the result register; a removal that leaves entries behind
//   first reads the new end back from ram; an insert into a non-empty
//   list walks over each held entry that is not below the new value
//   (worst case the whole list), reading and moving one ram entry per
//   cycle through a single compare. busy_o stays high until the result is
//   registered, so one request is in flight at a time; a new request may
//   start in the cycle that done_o is shown.
//   Values sit in a ring buffer in ram, so removing either end is one step.
//   Reset empties the list at once; the ram is not cleared.
//   The receiver cannot stall: each result beat is shown once and is gone.

module sorted_double_ended_queue #(
  parameter int unsigned CAPACITY = sdq_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [sdq_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [sdq_pkg::VALUE_W-1:0]  value_i,
  output logic                                done_o,
  output logic [sdq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [sdq_pkg::VALUE_W-1:0]  removed_value_o,
  output logic [sdq_pkg::COUNT_W-1:0]         count_o,
  output logic signed [sdq_pkg::VALUE_W-1:0]  min_value_o,
  output logic signed [sdq_pkg::VALUE_W-1:0]  max_value_o
);

  sdq_pkg::rsp_t rsp;
  logic          ctrl_busy;
  logic          done_q;

  sdq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy_o),
    .mode_i  (mode_i),
    .value_i (value_i),
    .busy_o  (ctrl_busy),
    .rsp_o   (rsp)
  );

  assign busy_o = ctrl_busy;

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rsp.valid;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (rsp.valid) begin
      status_o        <= rsp.status;
      removed_value_o <= rsp.removed;
      count_o         <= rsp.count;
      min_value_o     <= rsp.min_value;
      max_value_o     <= rsp.max_value;
    end
  end

  assign done_o = done_q;

endmodule

@@ rtl/sdq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/sdq_ctrl.sv @@
// sequencer for the sorted queue: ring pointers, count, min/max tracking
// and the insert walk over one shared compare; depends on sdq_pkg, sdq_ram
`timescale 1ns / 1ps

module sdq_ctrl #(
  parameter int unsigned CAPACITY = sdq_pkg::CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sdq_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [sdq_pkg::VALUE_W-1:0] value_i,
  output logic                              busy_o,
  output sdq_pkg::rsp_t                     rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VW = sdq_pkg::VALUE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_FMIN  = 3'd3;
  localparam logic [2:0] S_FMAX  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  // ring pointer step with wrap at the capacity
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  logic [2:0]                     state_q, state_d;
  logic signed [VW-1:0]           value_q, value_d;
  logic [sdq_pkg::STATUS_W-1:0]   status_q, status_d;
  logic signed [VW-1:0]           removed_q, removed_d;
  logic [CW-1:0]                  count_q, count_d;
  logic [CW-1:0]                  steps_q, steps_d;
  logic [AW-1:0]                  head_q, head_d;
  logic [AW-1:0]                  tail_q, tail_d;
  logic [AW-1:0]                  wr_q, wr_d;
  logic [AW-1:0]                  rd_q, rd_d;
  logic signed [VW-1:0]           min_q, min_d;
  logic signed [VW-1:0]           max_q, max_d;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [VW-1:0]                  ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [VW-1:0]                  ram_rdata;
  logic signed [VW-1:0]           rd_val;
  logic                           shift_up;
  logic [CW+4:0]                  count_wide;

  sdq_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare: entry at or above the new value moves up one slot
  assign rd_val   = $signed(ram_rdata);
  assign shift_up = (rd_val >= value_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    status_d  = status_q;
    removed_d = removed_q;
    count_d   = count_q;
    steps_d   = steps_q;
    head_d    = head_q;
    tail_d    = tail_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    min_d     = min_q;
    max_d     = max_q;
    ram_we    = 1'b0;
    ram_waddr = wr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          value_d   = value_i;
          status_d  = sdq_pkg::ST_DONE;
          removed_d = '0;
          state_d   = S_RESP;
          unique case (mode_i)
            sdq_pkg::MODE_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = sdq_pkg::ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
                tail_d  = ptr_inc(tail_q);
                if (count_q == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = tail_q;
                  ram_wdata = value_i;
                  min_d     = value_i;
                  max_d     = value_i;
                end else begin
                  if (value_i <= min_q) min_d = value_i;
                  if (value_i > max_q) max_d = value_i;
                  wr_d      = tail_q;
                  rd_d      = ptr_dec(tail_q);
                  steps_d   = count_q;
                  ram_re    = 1'b1;
                  ram_raddr = ptr_dec(tail_q);
                  state_d   = S_CMP;
                end
              end
            end
            sdq_pkg::MODE_REM_MIN: begin
              if (count_q == '0) begin
                status_d = sdq_pkg::ST_EMPTY;
              end else begin
                removed_d = min_q;
                head_d    = ptr_inc(head_q);
                count_d   = count_q - 1'b1;
                if (count_q != CW'(1)) begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_inc(head_q);
                  state_d   = S_FMIN;
                end
              end
            end
            sdq_pkg::MODE_REM_MAX: begin
              if (count_q == '0) begin
                status_d = sdq_pkg::ST_EMPTY;
              end else begin
                removed_d = max_q;
                tail_d    = ptr_dec(tail_q);
                count_d   = count_q - 1'b1;
                if (count_q != CW'(1)) begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_dec(ptr_dec(tail_q));
                  state_d   = S_FMAX;
                end
              end
            end
            default: begin
              // unused code: report the list unchanged
            end
          endcase
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        if (shift_up) begin
          ram_waddr = wr_q;
          ram_wdata = ram_rdata;
          wr_d      = rd_q;
          rd_d      = ptr_dec(rd_q);
          steps_d   = steps_q - 1'b1;
          if (steps_q == CW'(1)) begin
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec(rd_q);
          end
        end else begin
          ram_waddr = wr_q;
          ram_wdata = value_q;
          state_d   = S_RESP;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_q;
        ram_wdata = value_q;
        state_d   = S_RESP;
      end
      S_FMIN: begin
        min_d   = rd_val;
        state_d = S_RESP;
      end
      S_FMAX: begin
        max_d   = rd_val;
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    steps_q   <= steps_d;
    wr_q      <= wr_d;
    rd_q      <= rd_d;
    min_q     <= min_d;
    max_q     <= max_d;
  end

  // response beat, count folded to the field width
  assign count_wide = {5'b0, count_q};

  assign busy_o          = (state_q != S_IDLE);
  assign rsp_o.valid     = (state_q == S_RESP);
  assign rsp_o.status    = status_q;
  assign rsp_o.removed   = removed_q;
  assign rsp_o.count     = count_wide[4:0];
  assign rsp_o.min_value = (count_q == '0) ? '0 : min_q;
  assign rsp_o.max_value = (count_q == '0) ? '0 : max_q;

endmodule

@@ rtl/sdq_checker.sv @@
// port-level checks for the sorted double-ended queue, bound to the top
// depends on sdq_pkg and sorted_double_ended_queue
`timescale 1ns / 1ps

module sdq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                done_o,
  input logic [sdq_pkg::STATUS_W-1:0]        status_o,
  input logic signed [sdq_pkg::VALUE_W-1:0]  removed_value_o,
  input logic [sdq_pkg::COUNT_W-1:0]         count_o,
  input logic signed [sdq_pkg::VALUE_W-1:0]  min_value_o,
  input logic signed [sdq_pkg::VALUE_W-1:0]  max_value_o
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after an accepted request");

  // result beats never come back to back
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result beats in a row");

  // a rejected or empty request removes nothing
  a_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != sdq_pkg::ST_DONE) |-> (removed_value_o == '0))
    else $error("removed value on a failed request");

  // an empty report leaves the list empty
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == sdq_pkg::ST_EMPTY) |->
      (count_o == '0 && min_value_o == '0 && max_value_o == '0))
    else $error("empty status with a non-empty list");

  // the reported minimum never lies above the reported maximum
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && count_o != '0) |-> (min_value_o <= max_value_o))
    else $error("minimum above maximum");

endmodule

bind sorted_double_ended_queue sdq_checker u_sdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .status_o        (status_o),
  .removed_value_o (removed_value_o),
  .count_o         (count_o),
  .min_value_o     (min_value_o),
  .max_value_o     (max_value_o)
);
